FILE: hdl/rht_pkg.sv
// ============================================================================
// rht_pkg
// Shared types and constants for the region hit test unit: field widths,
// request codes, controller states and the command/status bundles between
// the controller and the datapath.
// ============================================================================
package rht_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 12;
    localparam int SLOT_BITS  = 4;

    // Request kinds
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // One stored rectangle
    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } t_rect;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_POST
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic store_en;     // write the request rectangle into the table
        logic latch_point;  // capture the query point
        logic clr_idx;      // restart the table walk at entry zero
        logic rd_en;        // read the table at the walk index
        logic save_result;  // capture the compare outcome
        logic load_out;     // move the saved result to the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cmp_vld;      // compare stage holds a fresh entry
        logic cmp_hit;      // that entry is enabled and holds the point
        logic cmp_last;     // that entry is the last of the table
        logic out_free;     // output register can take a new beat
    } t_dp_status;

endpackage

FILE: hdl/rht_req_if.sv
// ============================================================================
// rht_req_if
// Request channel: valid/ready handshake with a store or query payload.
// ============================================================================
interface rht_req_if;
    import rht_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [SLOT_BITS-1:0]  region_slot;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;

    modport source (
        output valid, req_type, region_slot, pos_x, pos_y, rect_width, rect_height,
        input  ready
    );

    modport sink (
        input  valid, req_type, region_slot, pos_x, pos_y, rect_width, rect_height,
        output ready
    );

endinterface

FILE: hdl/rht_rsp_if.sv
// ============================================================================
// rht_rsp_if
// Response channel: valid/ready handshake with the hit flag and hit slot.
// ============================================================================
interface rht_rsp_if;
    import rht_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [SLOT_BITS-1:0] hit_slot;

    modport source (
        output valid, hit, hit_slot,
        input  ready
    );

    modport sink (
        input  valid, hit, hit_slot,
        output ready
    );

endinterface

FILE: hdl/rht_ctrl.sv
// ============================================================================
// rht_ctrl
// Controller for the region hit test unit. Takes request beats, runs the
// table walk for a query and hands the result to the output register.
// ============================================================================
module rht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_req_type,
    input  rht_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output rht_pkg::t_ctrl_cmd  o_cmd
);
    import rht_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_req_type == REQ_QUERY) begin
                        o_cmd.latch_point = 1'b1;
                        o_cmd.clr_idx     = 1'b1;
                        n_state           = ST_WALK;
                    end else begin
                        o_cmd.store_en = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                // advance the read while the compare stage looks for a match
                o_cmd.rd_en = 1'b1;
                if (i_status.cmp_vld && (i_status.cmp_hit || i_status.cmp_last)) begin
                    o_cmd.save_result = 1'b1;
                    n_state           = ST_POST;
                end
            end
            ST_POST: begin
                // hold the result until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/rht_dpath.sv
// ============================================================================
// rht_dpath
// Datapath for the region hit test unit: rectangle table memory, enable
// bits, walk counter, compare stage, result staging and output register.
// ============================================================================
module rht_dpath #(
    parameter int NUM_REGIONS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rht_pkg::t_ctrl_cmd               i_cmd,
    input  logic [rht_pkg::SLOT_BITS-1:0]    i_region_slot,
    input  logic [rht_pkg::COORD_BITS-1:0]   i_pos_x,
    input  logic [rht_pkg::COORD_BITS-1:0]   i_pos_y,
    input  logic [rht_pkg::COORD_BITS-1:0]   i_rect_width,
    input  logic [rht_pkg::COORD_BITS-1:0]   i_rect_height,
    input  logic                             i_out_ready,
    output rht_pkg::t_dp_status              o_status,
    output logic                             o_out_valid,
    output logic                             o_hit,
    output logic [rht_pkg::SLOT_BITS-1:0]    o_hit_slot
);
    import rht_pkg::*;

    localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGIONS - 1);

    // Table storage
    t_rect                  mem [NUM_REGIONS];
    logic [NUM_REGIONS-1:0] r_enabled;

    // Walk and compare stage
    logic [IDX_W-1:0]       r_rd_idx;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_cmp_vld;
    logic                   r_cmp_en;
    t_rect                  r_rd_data;

    // Query point
    logic [COORD_BITS-1:0]  r_px;
    logic [COORD_BITS-1:0]  r_py;

    // Saved result and output register
    logic                   r_res_hit;
    logic [SLOT_BITS-1:0]   r_res_slot;
    logic                   r_out_vld;
    logic                   r_out_hit;
    logic [SLOT_BITS-1:0]   r_out_slot;

    logic [IDX_W+SLOT_BITS-1:0] wr_slot_ext;
    logic [IDX_W-1:0]           wr_addr;
    logic                       wr_in_range;
    logic [IDX_W+SLOT_BITS-1:0] cmp_idx_ext;
    logic [COORD_BITS:0]        right;
    logic [COORD_BITS:0]        bottom;
    logic                       inside_x;
    logic                       inside_y;
    logic                       cmp_hit;

    // Store address: slots beyond the table are dropped
    assign wr_slot_ext = {{IDX_W{1'b0}}, i_region_slot};
    assign wr_addr     = wr_slot_ext[IDX_W-1:0];
    assign wr_in_range = (32'(i_region_slot) < NUM_REGIONS);

    // Write the rectangle memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_en && wr_in_range) begin
            mem[wr_addr] <= '{left: i_pos_x, top: i_pos_y, w: i_rect_width, h: i_rect_height};
        end
    end

    // Read the rectangle memory at the walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    // Enable bits: set on store, clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= '0;
        end else if (i_cmd.store_en && wr_in_range) begin
            r_enabled[wr_addr] <= 1'b1;
        end
    end

    // Walk counter: stop at the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.clr_idx) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_en && (r_rd_idx != LAST_IDX)) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    // Compare stage tags follow the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cmp_idx <= r_rd_idx;
            r_cmp_en  <= r_enabled[r_rd_idx];
        end
    end

    // Capture the query point
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_point) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    // Inclusive bounds test, edges summed one bit wider
    assign right    = {1'b0, r_rd_data.left} + {1'b0, r_rd_data.w};
    assign bottom   = {1'b0, r_rd_data.top} + {1'b0, r_rd_data.h};
    assign inside_x = (r_px >= r_rd_data.left) && ({1'b0, r_px} <= right);
    assign inside_y = (r_py >= r_rd_data.top) && ({1'b0, r_py} <= bottom);
    assign cmp_hit  = r_cmp_en && inside_x && inside_y;

    assign cmp_idx_ext = {{SLOT_BITS{1'b0}}, r_cmp_idx};

    // Save the walk outcome
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_result) begin
            r_res_hit  <= cmp_hit;
            r_res_slot <= cmp_hit ? cmp_idx_ext[SLOT_BITS-1:0] : '0;
        end
    end

    // Output register: load a beat, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit  <= r_res_hit;
            r_out_slot <= r_res_slot;
        end
    end

    // Status back to the controller
    assign o_status.cmp_vld  = r_cmp_vld;
    assign o_status.cmp_hit  = cmp_hit;
    assign o_status.cmp_last = (r_cmp_idx == LAST_IDX);
    assign o_status.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_hit       = r_out_hit;
    assign o_hit_slot  = r_out_slot;

endmodule

FILE: hdl/region_hit_test_unit.sv
// ============================================================================
// region_hit_test_unit
// Table of rectangles with enable flags. A store beat writes a rectangle
// into a slot and enables it; a query beat returns the lowest enabled slot
// whose rectangle holds the point, or a miss.
//
//   Channel | Port  | Dir | Beat contents
//   --------+-------+-----+-------------------------------------------------
//   request | i_req | in  | req_type, region_slot, pos_x, pos_y,
//           |       |     | rect_width, rect_height
//   result  | o_rsp | out | hit, hit_slot (one beat per query, none on store)
//
// A query walks the table one entry per cycle through the memory read
// port and compare stage, and stops early when an entry matches.
// Reset clears all enable flags at once; no clearing pass is needed.
// A result waiting in the output register does not block stores; a query
// holds its result until the output register frees up.
// ============================================================================
module region_hit_test_unit #(
    parameter int NUM_REGIONS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rht_req_if.sink  i_req,
    rht_rsp_if.source o_rsp
);
    import rht_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       in_ready;

    rht_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_in_req_type (i_req.req_type),
        .i_status      (status),
        .o_in_ready    (in_ready),
        .o_cmd         (cmd)
    );

    rht_dpath #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_region_slot (i_req.region_slot),
        .i_pos_x       (i_req.pos_x),
        .i_pos_y       (i_req.pos_y),
        .i_rect_width  (i_req.rect_width),
        .i_rect_height (i_req.rect_height),
        .i_out_ready   (o_rsp.ready),
        .o_status      (status),
        .o_out_valid   (o_rsp.valid),
        .o_hit         (o_rsp.hit),
        .o_hit_slot    (o_rsp.hit_slot)
    );

    assign i_req.ready = in_ready;

endmodule

FILE: verif/tb_region_hit_test_unit.sv
// ============================================================================
// tb_region_hit_test_unit
// Self-checking bench for the region hit test unit. A directed table covers
// the cleared table, point and line rectangles, inclusive edges, the
// corners of the coordinate space, slot priority and rewrites. Random
// store and query beats follow, with most queries aimed at or around
// stored rectangles. A shadow table predicts random results; directed
// rows carry typed results. Both channels idle and stall in random bursts.
// ============================================================================
module tb_region_hit_test_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rht_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_BEATS = 1800;
    localparam int QUIET_TAIL   = 200;
    localparam int PAUSE_AT     = 900;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    localparam logic [COORD_BITS-1:0] COORD_MAX  = '1;
    localparam logic [COORD_BITS-1:0] SMALL_MASK = 'h03F;
    localparam logic [COORD_BITS-1:0] MID_MASK   = 'h3FF;

    typedef struct packed {
        logic                  req_type;
        logic [SLOT_BITS-1:0]  slot;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } t_request;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
    } t_answer;

    typedef struct packed {
        logic    given;
        t_answer ans;
    } t_given_answer;

    typedef struct packed {
        t_request      req;
        t_given_answer typed;
    } t_probe_row;

    logic i_clk;
    logic i_rst_n;

    rht_req_if req_bus ();
    rht_rsp_if rsp_bus ();

    region_hit_test_unit #(
        .NUM_REGIONS (NUM_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow of the rectangle table
    logic  shadow_en   [NUM_SLOTS];
    t_rect shadow_rect [NUM_SLOTS];

    t_answer       pending_hits [$];
    t_given_answer typed_answers [$];
    t_probe_row    probe_rows [$];

    int err_count  = 0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Lowest enabled slot holding the point; edges are inclusive
    function automatic t_answer lookup_point(logic [COORD_BITS-1:0] px,
                                             logic [COORD_BITS-1:0] py);
        t_answer              a;
        logic [COORD_BITS:0]  right;
        logic [COORD_BITS:0]  bottom;
        a = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            right  = {1'b0, shadow_rect[i].left} + {1'b0, shadow_rect[i].w};
            bottom = {1'b0, shadow_rect[i].top} + {1'b0, shadow_rect[i].h};
            if (shadow_en[i] && px >= shadow_rect[i].left && {1'b0, px} <= right &&
                py >= shadow_rect[i].top && {1'b0, py} <= bottom) begin
                a.hit  = 1'b1;
                a.slot = i[SLOT_BITS-1:0];
            end
        end
        return a;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        bit [31:0] raw;
        raw = $urandom;
        return raw[COORD_BITS-1:0];
    endfunction

    // Pick a coordinate on, inside or just outside the span lo .. lo + ext
    function automatic logic [COORD_BITS-1:0] pick_coord(logic [COORD_BITS-1:0] lo,
                                                         logic [COORD_BITS-1:0] ext);
        int v;
        case ($urandom_range(0, 5))
            0: v = int'(lo);
            1: v = int'(lo) + int'(ext);
            2: v = int'(lo) + int'(ext) + 1;
            3: v = int'(lo) - 1;
            default: v = int'(lo) + int'($urandom_range(0, ext));
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > int'(COORD_MAX)) begin
            v = int'(COORD_MAX);
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_request make_random_request();
        t_request r;
        int       k;
        int       sz;
        r.slot = SLOT_BITS'(rand_coord());
        r.x    = rand_coord();
        r.y    = rand_coord();
        r.w    = rand_coord();
        r.h    = rand_coord();
        if ($urandom_range(0, 99) < 30) begin
            r.req_type = REQ_STORE;
            // Mostly small rectangles so that misses stay common
            sz = $urandom_range(0, 9);
            if (sz < 6) begin
                r.w &= SMALL_MASK;
                r.h &= SMALL_MASK;
            end else if (sz < 8) begin
                r.w &= MID_MASK;
                r.h &= MID_MASK;
            end else if (sz == 8) begin
                r.w = '0;
            end
        end else begin
            r.req_type = REQ_QUERY;
            // Aim most queries at a stored rectangle and its edges
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, NUM_SLOTS - 1);
                if (shadow_en[k]) begin
                    r.x = pick_coord(shadow_rect[k].left, shadow_rect[k].w);
                    r.y = pick_coord(shadow_rect[k].top, shadow_rect[k].h);
                end
            end
        end
        return r;
    endfunction

    function automatic void add_row(logic kind, logic [SLOT_BITS-1:0] slot,
                                    logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                    logic [COORD_BITS-1:0] w, logic [COORD_BITS-1:0] h,
                                    logic given, logic hit, logic [SLOT_BITS-1:0] hit_slot);
        t_probe_row row;
        row.req         = '{kind, slot, x, y, w, h};
        row.typed.given = given;
        row.typed.ans   = '{hit, hit_slot};
        probe_rows.push_back(row);
    endfunction

    task automatic note_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    // Drive one request beat and hold it until accepted
    task automatic send_request(t_request r, t_given_answer typed);
        typed_answers.push_back(typed);
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= r.req_type;
        req_bus.region_slot <= r.slot;
        req_bus.pos_x       <= r.x;
        req_bus.pos_y       <= r.y;
        req_bus.rect_width  <= r.w;
        req_bus.rect_height <= r.h;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    task automatic maybe_gap();
        if (tx_idle_on && $urandom_range(0, 99) < 20) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Check result beats, then track accepted request beats
    always @(posedge i_clk) begin : scoreboard
        t_answer       got;
        t_answer       want;
        t_given_answer typed;
        t_request      acc;
        if (rsp_bus.valid && rsp_bus.ready) begin
            got.hit  = rsp_bus.hit;
            got.slot = rsp_bus.hit_slot;
            if (pending_hits.size() == 0) begin
                note_error($sformatf("result beat with nothing pending: hit=%0b slot=%0d",
                                     got.hit, got.slot));
            end else begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit) begin
                    note_error($sformatf("hit: expected %0b, got %0b", want.hit, got.hit));
                end
                if (got.slot !== want.slot) begin
                    note_error($sformatf("hit_slot: expected %0d, got %0d",
                                         want.slot, got.slot));
                end
            end
        end
        if (req_bus.valid && req_bus.ready) begin
            acc = '{req_bus.req_type, req_bus.region_slot, req_bus.pos_x, req_bus.pos_y,
                    req_bus.rect_width, req_bus.rect_height};
            typed = (typed_answers.size() != 0) ? typed_answers.pop_front() : '0;
            if (acc.req_type == REQ_STORE) begin
                shadow_en[acc.slot]   = 1'b1;
                shadow_rect[acc.slot] = '{left: acc.x, top: acc.y, w: acc.w, h: acc.h};
            end else begin
                pending_hits.push_back(typed.given ? typed.ans : lookup_point(acc.x, acc.y));
            end
        end
    end

    // Result side ready, with stall bursts
    initial begin : sink_pacing
        int stall_left;
        rsp_bus.ready = 1'b0;
        stall_left    = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_bus.ready <= 1'b0;
            end else if (!rx_idle_on) begin
                stall_left = 0;
                rsp_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 20) begin
                stall_left = $urandom_range(0, 8);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // End the run when nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_STORE;
        req_bus.region_slot = '0;
        req_bus.pos_x       = '0;
        req_bus.pos_y       = '0;
        req_bus.rect_width  = '0;
        req_bus.rect_height = '0;
        i_rst_n             = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_en[i]   = 1'b0;
            shadow_rect[i] = '0;
        end

        // Directed table: kind, slot, x, y, w, h, typed, hit, hit_slot
        // Cleared table misses everywhere
        add_row(REQ_QUERY, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(REQ_QUERY, 15, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 0);
        // Point rectangle at the origin
        add_row(REQ_STORE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_QUERY, 0, 0, 0, 0, 0, 1, 1, 0);
        add_row(REQ_QUERY, 0, 1, 0, 0, 0, 1, 0, 0);
        add_row(REQ_QUERY, 0, 0, 1, 0, 0, 1, 0, 0);
        // Largest rectangle at the far corner, edge sums past the coordinate range
        add_row(REQ_STORE, 15, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0);
        add_row(REQ_QUERY, 0, COORD_MAX, COORD_MAX, 0, 0, 1, 1, 15);
        add_row(REQ_QUERY, 0, COORD_MAX - 1, COORD_MAX, 0, 0, 1, 0, 0);
        // Horizontal line: zero height, inclusive right edge
        add_row(REQ_STORE, 5, 100, 200, 50, 0, 0, 0, 0);
        add_row(REQ_QUERY, 0, 150, 200, 0, 0, 1, 1, 5);
        add_row(REQ_QUERY, 0, 151, 200, 0, 0, 1, 0, 0);
        add_row(REQ_QUERY, 0, 99, 200, 0, 0, 1, 0, 0);
        add_row(REQ_QUERY, 0, 100, 201, 0, 0, 1, 0, 0);
        add_row(REQ_QUERY, 0, 100, 199, 0, 0, 1, 0, 0);
        // Full-screen rectangle: lower slot wins on overlap
        add_row(REQ_STORE, 3, 0, 0, COORD_MAX, COORD_MAX, 0, 0, 0);
        add_row(REQ_QUERY, 0, 150, 200, 0, 0, 1, 1, 3);
        add_row(REQ_QUERY, 0, COORD_MAX, COORD_MAX, 0, 0, 1, 1, 3);
        add_row(REQ_QUERY, 0, 0, 0, 0, 0, 1, 1, 0);
        // Rewrite an enabled slot
        add_row(REQ_STORE, 3, 2048, 2048, 1, 1, 0, 0, 0);
        add_row(REQ_QUERY, 0, 150, 200, 0, 0, 1, 1, 5);
        add_row(REQ_QUERY, 0, 2049, 2049, 0, 0, 1, 1, 3);
        add_row(REQ_QUERY, 15, 2050, 2049, COORD_MAX, COORD_MAX, 1, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (probe_rows[i]) begin
            send_request(probe_rows[i].req, probe_rows[i].typed);
            maybe_gap();
        end

        // Random beats; idling on in most stretches, off in the tail
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            tx_idle_on = (n < RANDOM_BEATS - QUIET_TAIL) && ((n / 150) % 3 != 2);
            rx_idle_on = (n < RANDOM_BEATS - QUIET_TAIL) && ((n / 150) % 3 != 1);
            if (n == PAUSE_AT) begin
                // Hold off until every pending result has drained
                req_bus.valid <= 1'b0;
                do @(posedge i_clk); while (pending_hits.size() != 0);
            end
            send_request(make_random_request(), '0);
            maybe_gap();
        end

        // Drain and report
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
